### src/chd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_pkg
// shared types and constants for the single chunk decoder
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int LEN_BITS = 32;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_BADCHAR = 2'd2;
  localparam logic [1:0] KIND_LENGTH  = 2'd3;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } chd_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
  } chd_out_t;

endpackage
`default_nettype wire

### src/chunked_http_single_chunk_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_http_single_chunk_decoder
// decodes a message holding one chunk: hex length, CR LF, payload, CR LF
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) takes one message byte per beat,
//   in_last set on the final byte of the message
//   out channel (out_valid/out_ready/out_data) gives zero or one result per
//   input beat: a payload byte, a message ok, or an error kind
//   a result is registered and appears in the cycle after the beat that causes it
//   throughput: one beat per cycle unless the receiver stalls, set by the single
//   parse stage that updates the phase, length and result registers together
//   in_ready is high while the result register is empty or being taken, so a
//   stalled receiver holds the pending result and stops input after it
//   after an error, bytes are dropped silently up to the final byte
//   reset (rst_n low, synchronous) returns to the hex length phase with a
//   zero length and an empty result register
// ----------------------------------------------------------------------------
module chunked_http_single_chunk_decoder
  import chd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire chd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output chd_out_t      out_data
);

  localparam logic [2:0] PH_HEX     = 3'd0;
  localparam logic [2:0] PH_LEN_LF  = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_END_CR  = 3'd3;
  localparam logic [2:0] PH_END_LF  = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]          phase_r, phase_nxt;
  logic [LEN_BITS-1:0] remaining_r, remaining_nxt;
  logic                out_valid_r, out_valid_nxt;
  chd_out_t            out_data_r, out_data_nxt;

  logic                in_acc;
  logic                is_hex;
  logic [3:0]          hex_val;
  logic                emit;
  logic [1:0]          emit_kind;
  logic                fail;
  logic [7:0]          b;
  logic                last;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    emit          = 1'b0;
    emit_kind     = KIND_DATA;
    fail          = 1'b0;
    unique case (phase_r)
      PH_HEX: begin
        if (is_hex) begin
          if (remaining_r[LEN_BITS-1 -: 4] != 4'd0 || last) begin
            fail = 1'b1; emit_kind = KIND_LENGTH;
          end else begin
            remaining_nxt = {remaining_r[LEN_BITS-5:0], hex_val};
          end
        end else if (b != CH_CR) begin
          fail = 1'b1; emit_kind = KIND_BADCHAR;
        end else if (last) begin
          fail = 1'b1; emit_kind = KIND_LENGTH;
        end else begin
          phase_nxt = PH_LEN_LF;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          fail = 1'b1; emit_kind = KIND_BADCHAR;
        end else if (last) begin
          fail = 1'b1; emit_kind = KIND_LENGTH;
        end else begin
          phase_nxt = (remaining_r == '0) ? PH_END_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        if (last) begin
          fail = 1'b1; emit_kind = KIND_LENGTH;
        end else begin
          emit          = 1'b1;
          emit_kind     = KIND_DATA;
          remaining_nxt = remaining_r - LEN_BITS'(1);
          if (remaining_r == LEN_BITS'(1)) phase_nxt = PH_END_CR;
        end
      end
      PH_END_CR: begin
        if (b != CH_CR) begin
          fail = 1'b1; emit_kind = KIND_BADCHAR;
        end else if (last) begin
          fail = 1'b1; emit_kind = KIND_LENGTH;
        end else begin
          phase_nxt = PH_END_LF;
        end
      end
      PH_END_LF: begin
        if (b != CH_LF) begin
          fail = 1'b1; emit_kind = KIND_BADCHAR;
        end else if (!last) begin
          fail = 1'b1; emit_kind = KIND_LENGTH;
        end else begin
          emit          = 1'b1;
          emit_kind     = KIND_OK;
          phase_nxt     = PH_HEX;
          remaining_nxt = '0;
        end
      end
      default: begin
        if (last) begin
          phase_nxt     = PH_HEX;
          remaining_nxt = '0;
        end
      end
    endcase
    if (fail) begin
      emit = 1'b1;
      if (last) begin
        phase_nxt     = PH_HEX;
        remaining_nxt = '0;
      end else begin
        phase_nxt = PH_DISCARD;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (in_acc && emit) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_kind = emit_kind;
      out_data_nxt.out_byte = (emit_kind == KIND_DATA) ? b : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEX;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r     <= phase_nxt;
        remaining_r <= remaining_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (remaining_r != '0))
    else $error("payload phase with zero length left");

  a_byte_zero_off_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_kind != KIND_DATA) |-> (out_data_r.out_byte == 8'h00))
    else $error("nonzero byte on status result");

  a_payload_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_DATA && !last) |=>
      (out_valid_r && out_data_r.out_kind == KIND_DATA && out_data_r.out_byte == $past(b)))
    else $error("payload beat not forwarded");

endmodule
`default_nettype wire
